@@ src/websocket_frame_deframer_defines.svh @@
// Assertion macros shared by the deframer modules
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`ifndef ASSERT_OFF
`define WFD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define WFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define WFD_ASSERT(lbl, prop, msg)
`define WFD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/wfd_pkg.sv @@
// Types and constants shared by the WebSocket deframer modules
`default_nettype none
package wfd_pkg;

	localparam logic [6:0]  LEN16_CODE    = 7'd126;
	localparam logic [6:0]  LEN64_CODE    = 7'd127;
	localparam logic [3:0]  EXT16_BYTES   = 4'd2;
	localparam logic [3:0]  EXT64_BYTES   = 4'd8;
	localparam logic [31:0] MAX_LEN_RESET = 32'd65536;

	typedef struct packed {
		logic        is_header;
		logic [3:0]  frame_opcode;
		logic [3:0]  message_opcode;
		logic        final_frame;
		logic        was_masked;
		logic [31:0] frame_length;
		logic        oversize;
		logic [7:0]  payload_byte;
		logic        last_of_frame;
		logic        last_of_message;
	} wfd_result_t;

endpackage
`default_nettype wire

@@ src/wfd_in_skid.sv @@
// Two-entry input skid buffer for the incoming byte stream
`default_nettype none
module wfd_in_skid (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	output logic            head_valid,
	output logic [7:0]      head_byte,
	input  wire logic       head_take
);

	logic [1:0] cnt_q;
	logic [7:0] b0_q;
	logic [7:0] b1_q;
	logic       push;

	assign in_stall   = (cnt_q == 2'd2);
	assign push       = in_valid && !in_stall;
	assign head_valid = (cnt_q != 2'd0);
	assign head_byte  = b0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			unique case ({push, head_take})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case ({push, head_take})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					b0_q <= data_byte;
				end else begin
					b1_q <= data_byte;
				end
			end
			2'b01: begin
				b0_q <= b1_q;
			end
			2'b11: begin
				// head leaves; the new request lands behind whatever remains
				if (cnt_q == 2'd1) begin
					b0_q <= data_byte;
				end else begin
					b0_q <= b1_q;
					b1_q <= data_byte;
				end
			end
			default: begin
				b0_q <= b0_q;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ src/wfd_parser.sv @@
// Frame header parser, unmasking and per-byte result generation
`default_nettype none
`include "websocket_frame_deframer_defines.svh"
module wfd_parser
	import wfd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire logic [7:0]  data_byte,
	input  wire logic [31:0] max_len,
	output logic             res_valid,
	output wfd_result_t      res
);

	localparam logic [2:0] PH_FIRST   = 3'd0;
	localparam logic [2:0] PH_SECOND  = 3'd1;
	localparam logic [2:0] PH_EXTLEN  = 3'd2;
	localparam logic [2:0] PH_KEY     = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;

	logic [2:0]  phase_q,  phase_d;
	logic [3:0]  btc_q,    btc_d;
	logic        fin_q,    fin_d;
	logic        mask_q,   mask_d;
	logic [3:0]  cur_q,    cur_d;
	logic [3:0]  first_q,  first_d;
	logic        mid_q,    mid_d;
	logic [63:0] acc_q,    acc_d;
	logic [31:0] key_q,    key_d;
	logic [63:0] rem_q,    rem_d;
	logic [1:0]  kp_q,     kp_d;

	logic        after_len;
	logic        emit_hdr;
	logic        is_pay;
	logic        lof;
	logic        end_fr;
	logic [7:0]  pbyte;
	logic [7:0]  kbyte;

	always_comb begin
		phase_d   = phase_q;
		btc_d     = btc_q;
		fin_d     = fin_q;
		mask_d    = mask_q;
		cur_d     = cur_q;
		first_d   = first_q;
		mid_d     = mid_q;
		acc_d     = acc_q;
		key_d     = key_q;
		rem_d     = rem_q;
		kp_d      = kp_q;
		after_len = 1'b0;
		emit_hdr  = 1'b0;
		is_pay    = 1'b0;
		lof       = 1'b0;
		end_fr    = 1'b0;
		pbyte     = 8'd0;
		kbyte     = key_q[{kp_q, 3'b000} +: 8];

		unique case (phase_q)
			PH_SECOND: begin
				mask_d = data_byte[7];
				if (data_byte[6:0] == LEN16_CODE) begin
					btc_d   = EXT16_BYTES;
					phase_d = PH_EXTLEN;
				end else if (data_byte[6:0] == LEN64_CODE) begin
					btc_d   = EXT64_BYTES;
					phase_d = PH_EXTLEN;
				end else begin
					acc_d     = {57'd0, data_byte[6:0]};
					after_len = 1'b1;
				end
			end
			PH_EXTLEN: begin
				// big-endian: shift earlier bytes up
				acc_d = {acc_q[55:0], data_byte};
				if (btc_q <= 4'd1) begin
					btc_d     = 4'd0;
					after_len = 1'b1;
				end else begin
					btc_d = btc_q - 4'd1;
				end
			end
			PH_KEY: begin
				key_d[{kp_q, 3'b000} +: 8] = key_q[{kp_q, 3'b000} +: 8] | data_byte;
				kp_d = kp_q + 2'd1;
				if (kp_q == 2'd3) begin
					emit_hdr = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				kp_d   = kp_q + 2'd1;
				rem_d  = rem_q - 64'd1;
				is_pay = 1'b1;
				pbyte  = data_byte ^ kbyte;
				lof    = (rem_d == 64'd0);
				end_fr = lof;
			end
			default: begin
				// first header byte; unused phase codes land here too
				fin_d   = data_byte[7];
				cur_d   = data_byte[3:0];
				key_d   = 32'd0;
				acc_d   = 64'd0;
				kp_d    = 2'd0;
				phase_d = PH_SECOND;
			end
		endcase

		if (after_len) begin
			if (mask_d) begin
				phase_d = PH_KEY;
				kp_d    = 2'd0;
			end else begin
				emit_hdr = 1'b1;
			end
		end

		if (emit_hdr) begin
			if (!mid_q) begin
				first_d = cur_q;
			end
			rem_d = acc_d;
			kp_d  = 2'd0;
			if (acc_d == 64'd0) begin
				lof    = 1'b1;
				end_fr = 1'b1;
			end else begin
				phase_d = PH_PAYLOAD;
			end
		end

		if (end_fr) begin
			mid_d   = !fin_q;
			phase_d = PH_FIRST;
		end
	end

	assign res_valid = emit_hdr || is_pay;

	always_comb begin
		res.is_header       = emit_hdr;
		res.frame_opcode    = cur_q;
		res.message_opcode  = first_d;
		res.final_frame     = fin_q;
		res.was_masked      = mask_d;
		res.frame_length    = (|acc_d[63:32]) ? 32'hFFFF_FFFF : acc_d[31:0];
		res.oversize        = (|acc_d[63:32]) || (acc_d[31:0] > max_len);
		res.payload_byte    = pbyte;
		res.last_of_frame   = lof;
		res.last_of_message = lof && fin_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			btc_q   <= 4'd0;
			fin_q   <= 1'b0;
			mask_q  <= 1'b0;
			cur_q   <= 4'd0;
			first_q <= 4'd0;
			mid_q   <= 1'b0;
			acc_q   <= 64'd0;
			key_q   <= 32'd0;
			rem_q   <= 64'd0;
			kp_q    <= 2'd0;
		end else if (take) begin
			phase_q <= phase_d;
			btc_q   <= btc_d;
			fin_q   <= fin_d;
			mask_q  <= mask_d;
			cur_q   <= cur_d;
			first_q <= first_d;
			mid_q   <= mid_d;
			acc_q   <= acc_d;
			key_q   <= key_d;
			rem_q   <= rem_d;
			kp_q    <= kp_d;
		end
	end

	`WFD_ASSERT(a_payload_rem, (phase_q == PH_PAYLOAD) |-> (rem_q != 64'd0), "payload phase with nothing left")
	`WFD_ASSERT_NEXT(a_ext64, take && (phase_q == PH_SECOND) && (data_byte[6:0] == LEN64_CODE), (phase_q == PH_EXTLEN) && (btc_q == EXT64_BYTES), "64-bit length not armed for eight bytes")

endmodule
`default_nettype wire

@@ src/websocket_frame_deframer.sv @@
// WebSocket frame deframer top level: config register, skid input, result register
//
// Usage:
//   Input channel (in_valid, in_stall, data_byte) takes one raw stream byte per request.
//   Output channel (out_valid, out_stall, result fields) gives one header request when a
//   frame header is complete, then one request per payload byte, unmasked.
//   Header bytes other than the last give no result.
//   cfg_we/cfg_wdata write max_frame_length (reset 65536); write only while idle.
// Timing:
//   A byte accepted on the input is held in the skid buffer, parsed by the combinational
//   parse step and then registered in the result register; one byte is taken every cycle
//   while out_stall does not hold the result register.
// Stall:
//   While out_stall holds, the result register keeps its request and the parser halts;
//   the two-entry skid buffer keeps taking bytes until both entries are full, then
//   in_stall rises (decoded from the registered entry count).
// Reset:
//   arst_n clears the parser to expect the first header byte of a new message and
//   empties both the skid buffer and the result register.
`default_nettype none
`include "websocket_frame_deframer_defines.svh"
module websocket_frame_deframer
	import wfd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             is_header,
	output logic [3:0]       frame_opcode,
	output logic [3:0]       message_opcode,
	output logic             final_frame,
	output logic             was_masked,
	output logic [31:0]      frame_length,
	output logic             oversize,
	output logic [7:0]       payload_byte,
	output logic             last_of_frame,
	output logic             last_of_message
);

	logic [31:0]  max_len_q;
	logic         head_valid;
	logic [7:0]   head_byte;
	logic         take;
	logic         slot_free;
	logic         res_valid;
	wfd_result_t  res;
	logic         out_valid_q;
	wfd_result_t  out_q;
	logic         empty_hdr_out;
	logic         pay_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	wfd_in_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.head_valid (head_valid),
		.head_byte  (head_byte),
		.head_take  (take)
	);

	// advance only when the result register is empty or being drained
	assign slot_free = !out_valid_q || !out_stall;
	assign take      = head_valid && slot_free;

	wfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (head_byte),
		.max_len   (max_len_q),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= take && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign is_header       = out_q.is_header;
	assign frame_opcode    = out_q.frame_opcode;
	assign message_opcode  = out_q.message_opcode;
	assign final_frame     = out_q.final_frame;
	assign was_masked      = out_q.was_masked;
	assign frame_length    = out_q.frame_length;
	assign oversize        = out_q.oversize;
	assign payload_byte    = out_q.payload_byte;
	assign last_of_frame   = out_q.last_of_frame;
	assign last_of_message = out_q.last_of_message;

	assign empty_hdr_out = out_valid && is_header && last_of_frame;
	assign pay_out       = out_valid && !is_header;

	`WFD_ASSERT(a_empty_hdr, empty_hdr_out |-> (frame_length == 32'd0), "empty header with a length")
	`WFD_ASSERT(a_payload_len, pay_out |-> (frame_length != 32'd0), "payload in a zero-length frame")

endmodule
`default_nettype wire
